// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both macros expect i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_PROP(lbl, !(cond), msg)
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== sv/ppu_pkg.sv =====
`timescale 1ns / 1ps
package ppu_pkg;

    localparam int POOL_SIZE_DEF = 64;
    localparam int STEP_W        = 16;
    localparam int FIX_W         = 32;
    localparam int LIFE_W        = 31;
    localparam int SLOT_W        = 6;
    localparam int COUNT_W       = 7;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_SPAWN = 1'b1;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_TICK,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              live;
        logic [LIFE_W-1:0] life;
        logic [FIX_W-1:0]  pos_x;
        logic [FIX_W-1:0]  pos_y;
        logic [FIX_W-1:0]  vel_x;
        logic [FIX_W-1:0]  vel_y;
        logic [FIX_W-1:0]  angle;
        logic [FIX_W-1:0]  spin;
    } t_slot_word;

endpackage

// ===== sv/particle_pool_update.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Pool of POOL_SIZE particle slots held in one slot memory with a single read and a single
// write port. After reset a clearing pass writes every slot free, during which no request
// is taken. A tick request sweeps the memory one slot a cycle through a read, multiply and
// write-back pipeline. A spawn request scans for the lowest free slot and gives its result
// once a slot is taken, or once the pool is found full, in which case the request is
// dropped. One request is worked on at a time; the next may be accepted while the previous
// result still waits in the output register.
module particle_pool_update import ppu_pkg::*; #(
    parameter int POOL_SIZE = POOL_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_kind,
    input  logic [STEP_W-1:0]   i_step,
    input  logic signed [FIX_W-1:0] i_spawn_pos_x,
    input  logic signed [FIX_W-1:0] i_spawn_pos_y,
    input  logic signed [FIX_W-1:0] i_spawn_vel_x,
    input  logic signed [FIX_W-1:0] i_spawn_vel_y,
    input  logic signed [FIX_W-1:0] i_spawn_angle,
    input  logic signed [FIX_W-1:0] i_spawn_spin,
    input  logic [LIFE_W-1:0]   i_spawn_life,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [SLOT_W-1:0]   o_slot,
    output logic                o_accepted,
    output logic [COUNT_W-1:0]  o_live_count
);

    localparam int AW   = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CW   = $clog2(POOL_SIZE + 1);
    localparam int WW   = $bits(t_slot_word);
    localparam int PW   = FIX_W + STEP_W + 1;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_idx;
    logic              r_kind;
    logic [STEP_W-1:0] r_step;
    t_slot_word        r_spawn;
    logic              r_s1_v;
    logic [AW-1:0]     r_s1_addr;
    logic              r_s2_v;
    logic [AW-1:0]     r_s2_addr;
    t_slot_word        r_s2_word;
    logic              r_s2_free;
    logic [FIX_W-1:0]  r_s2_dx, r_s2_dy, r_s2_da;
    logic [CW-1:0]     r_live_total;
    logic [AW-1:0]     r_res_slot;
    logic              r_res_ok;
    logic              r_o_valid;
    logic [SLOT_W-1:0] r_o_slot;
    logic              r_o_acc;
    logic [COUNT_W-1:0] r_o_live;

    logic              in_take;
    logic              out_load;
    logic              found;
    logic              scan_end;
    logic              ram_re, ram_we;
    logic [AW-1:0]     ram_waddr;
    t_slot_word        ram_wdata;
    t_slot_word        rd_word;
    t_slot_word        upd_word;
    logic [LIFE_W+1:0] life_n;
    logic signed [PW-1:0] prod_x, prod_y, prod_a;
    logic [31:0]       slot_ext, live_ext;

    ppu_ram #(
        .WIDTH (WW),
        .DEPTH (POOL_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_word)
    );

    assign in_take  = i_in_valid && (r_state == ST_IDLE);
    assign out_load = (r_state == ST_DONE) && (!r_o_valid || !i_out_stall);
    assign found    = (r_state == ST_SCAN) && r_s1_v && !rd_word.live;
    assign scan_end = (r_idx == CW'(POOL_SIZE));

    assign life_n = {2'b00, rd_word.life} - {{(LIFE_W + 2 - STEP_W){1'b0}}, r_step};
    assign prod_x = $signed(rd_word.vel_x) * $signed({1'b0, r_step});
    assign prod_y = $signed(rd_word.vel_y) * $signed({1'b0, r_step});
    assign prod_a = $signed(rd_word.spin) * $signed({1'b0, r_step});

    always_comb begin
        upd_word = r_s2_word;
        if (r_s2_free) begin
            upd_word.live = 1'b0;
        end else begin
            upd_word.pos_x = r_s2_word.pos_x + r_s2_dx;
            upd_word.pos_y = r_s2_word.pos_y + r_s2_dy;
            upd_word.angle = r_s2_word.angle + r_s2_da;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR: begin
                if (r_idx == CW'(POOL_SIZE - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_take) n_state = (i_kind == KIND_SPAWN) ? ST_SCAN : ST_TICK;
            end
            ST_TICK: begin
                if (scan_end && !r_s1_v && !r_s2_v) n_state = ST_DONE;
            end
            ST_SCAN: begin
                if (found || (scan_end && !r_s1_v)) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_CLR;
        endcase
    end

    always_comb begin
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = '0;
        case (r_state)
            ST_CLR: begin
                ram_we = 1'b1;
            end
            ST_TICK: begin
                ram_re    = !scan_end;
                ram_we    = r_s2_v && r_s2_word.live;
                ram_waddr = r_s2_addr;
                ram_wdata = upd_word;
            end
            ST_SCAN: begin
                ram_re    = !scan_end && !found;
                ram_we    = found;
                ram_waddr = r_s1_addr;
                ram_wdata = r_spawn;
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLR;
            r_idx        <= '0;
            r_s1_v       <= 1'b0;
            r_s2_v       <= 1'b0;
            r_live_total <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s1_v  <= ram_re;
            r_s2_v  <= (r_state == ST_TICK) && r_s1_v;
            if (in_take) begin
                r_idx <= '0;
            end else if (r_state == ST_CLR || ram_re) begin
                r_idx <= r_idx + 1'b1;
            end
            if (found) begin
                r_live_total <= r_live_total + 1'b1;
            end else if (r_state == ST_TICK && r_s2_v && r_s2_word.live && r_s2_free) begin
                r_live_total <= r_live_total - 1'b1;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign slot_ext = 32'(r_res_slot);
    assign live_ext = 32'(r_live_total);

    always_ff @(posedge i_clk) begin
        r_s1_addr <= r_idx[AW-1:0];
        r_s2_addr <= r_s1_addr;
        r_s2_word <= '{
            live:  rd_word.live,
            life:  life_n[LIFE_W-1:0],
            pos_x: rd_word.pos_x,
            pos_y: rd_word.pos_y,
            vel_x: rd_word.vel_x,
            vel_y: rd_word.vel_y,
            angle: rd_word.angle,
            spin:  rd_word.spin
        };
        r_s2_free <= life_n[LIFE_W+1] || (life_n == '0);
        r_s2_dx   <= prod_x[FIX_W+STEP_W-1:STEP_W];
        r_s2_dy   <= prod_y[FIX_W+STEP_W-1:STEP_W];
        r_s2_da   <= prod_a[FIX_W+STEP_W-1:STEP_W];
        if (in_take) begin
            r_kind     <= i_kind;
            r_step     <= i_step;
            r_spawn    <= '{
                live:  1'b1,
                life:  i_spawn_life,
                pos_x: i_spawn_pos_x,
                pos_y: i_spawn_pos_y,
                vel_x: i_spawn_vel_x,
                vel_y: i_spawn_vel_y,
                angle: i_spawn_angle,
                spin:  i_spawn_spin
            };
            r_res_slot <= '0;
            r_res_ok   <= (i_kind == KIND_TICK);
        end else if (found) begin
            r_res_slot <= r_s1_addr;
            r_res_ok   <= 1'b1;
        end
        if (out_load) begin
            r_o_slot <= slot_ext[SLOT_W-1:0];
            r_o_acc  <= r_res_ok;
            r_o_live <= live_ext[COUNT_W-1:0];
        end
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_o_valid;
    assign o_slot       = r_o_slot;
    assign o_accepted   = r_o_acc;
    assign o_live_count = r_o_live;

    `ASSERT_PROP(a_live_bound, (r_live_total <= CW'(POOL_SIZE)), "live count exceeds pool size")
    `ASSERT_NEVER(a_rw_clash, (ram_we && ram_re && (ram_waddr == r_idx[AW-1:0])), "slot clash")
    `ASSERT_PROP(a_take_start, (in_take |=> (r_state != ST_IDLE)), "request did not start")
    `ASSERT_PROP(a_out_done, ($rose(r_o_valid) |-> ($past(r_state) == ST_DONE)), "stray result")
    `ASSERT_NEVER(a_kind_mix, ((r_state == ST_SCAN) && (r_kind == KIND_TICK)), "tick in scan")

endmodule

// ===== sv/ppu_ram.sv =====
`timescale 1ns / 1ps
module ppu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
